// File: rtl/core/cfmo_pkg.sv
`default_nettype none

package cfmo_pkg;

  localparam int VOICES_DEF     = 16;
  localparam int PHASE_BITS_DEF = 32;
  localparam int SINE_BITS_DEF  = 10;

  // shared multiplier operand widths
  localparam int MUL_A_W = 56;
  localparam int MUL_B_W = 20;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [24:0] C4_Q16        = 25'd17145893;
  localparam logic [17:0] TURNS_PER_RAD = 18'd166886;
  // ceil(2^21 / 5), exact for 19-bit dividends
  localparam logic [18:0] DIV5_RECIP    = 19'd419431;

  localparam logic [12:0] PITCH_RST = 13'd0;
  localparam logic [15:0] RATIO_RST = 16'd4096;
  localparam logic [13:0] DEPTH_RST = 14'd0;
  localparam logic [14:0] DELAY_RST = 15'd0;
  localparam logic [19:0] STEP_RST  = 20'd89478;
  localparam logic [1:0]  OVS_RST   = 2'd0;

  localparam int APB_AW = 5;

  typedef enum logic [2:0] {
    REG_PITCH = 3'd0,
    REG_RATIO = 3'd1,
    REG_DEPTH = 3'd2,
    REG_DELAY = 3'd3,
    REG_STEP  = 3'd4,
    REG_OVS   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [3:0]         voice;
    logic signed [15:0] note_cv;
    logic signed [15:0] ratio_cv;
    logic               ratio_patched;
    logic signed [15:0] depth_cv;
    logic               depth_patched;
    logic signed [15:0] delay_cv;
  } item_t;

  typedef struct packed {
    logic [3:0]         out_voice;
    logic signed [15:0] audio_out;
  } result_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_EX1, ST_EX2, ST_EX3, ST_BASE1, ST_BASE2, ST_F0,
    ST_RDIV, ST_RSAT, ST_DDIV, ST_DSAT, ST_F1, ST_F2, ST_RT,
    ST_ADV, ST_X2, ST_X3A, ST_X3B, ST_X3C,
    ST_SIN_A, ST_SIN_B, ST_SIN_C, ST_SIN_D, ST_SIN_E,
    ST_MT1, ST_MT2, ST_MT3, ST_OUT
  } fsm_state_t;

  typedef enum logic [1:0] {
    OP_Y2,
    OP_Y3,
    OP_Y4
  } sine_op_t;

  // knob scaled by positive cv over 10 V; q is the already divided product
  function automatic logic [15:0] knob_scale(logic [15:0] knob, logic signed [15:0] cv,
                                             logic patched, logic [16:0] q);
    logic [15:0] v;
    v = knob;
    if (patched) begin
      if (cv > 16'sd0) begin
        v = q[16] ? 16'hFFFF : q[15:0];
      end else begin
        v = 16'd0;
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/cfmo_mul.sv
`default_nettype none

module cfmo_mul
  import cfmo_pkg::*;
(
  input  wire logic               clk,
  input  wire logic [MUL_A_W-1:0] a,
  input  wire logic [MUL_B_W-1:0] b,
  output logic      [MUL_P_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

`default_nettype wire

// File: rtl/core/cascaded_fm_oscillator.sv
`default_nettype none

// Three-operator cascaded FM oscillator for up to VOICES channels. Each request carries
// one audio sample's CVs for one voice and yields one output sample for that voice.
// All arithmetic runs through one registered 56x20 multiplier stepped by a sequencer:
// a sample's result is registered from the ST_OUT state, after which the sequencer
// returns to idle and the next request can be taken. A request for a voice number
// at or beyond VOICES goes straight from idle to ST_OUT and returns 0. ST_OUT waits
// while a stalled result still fills the output register. The block accepts no
// request while a sample is in work; a finished result waits in the output register
// while the next request is taken. Phase state lives in flops cleared by reset.
module cascaded_fm_oscillator
  import cfmo_pkg::*;
#(
  parameter int VOICES          = VOICES_DEF,
  parameter int PHASE_BITS      = PHASE_BITS_DEF,
  parameter int SINE_TABLE_BITS = SINE_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire item_t             item,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output result_t                result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  localparam int VW     = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SH_UP  = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
  localparam int SH_DN  = (PHASE_BITS >= 32) ? 0 : 32 - PHASE_BITS;
  localparam int STB    = SINE_TABLE_BITS;

  // configuration
  logic [12:0] pitch_offset;
  logic [15:0] ratio_knob;
  logic [13:0] depth_knob;
  logic [14:0] delay_knob;
  logic [19:0] phase_step_per_hz;
  logic [1:0]  oversample_log2;

  logic       cfg_we;
  reg_idx_t   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_offset      <= PITCH_RST;
      ratio_knob        <= RATIO_RST;
      depth_knob        <= DEPTH_RST;
      delay_knob        <= DELAY_RST;
      phase_step_per_hz <= STEP_RST;
      oversample_log2   <= OVS_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_PITCH: pitch_offset      <= pwdata[12:0];
        REG_RATIO: ratio_knob        <= pwdata[15:0];
        REG_DEPTH: depth_knob        <= pwdata[13:0];
        REG_DELAY: delay_knob        <= pwdata[14:0];
        REG_STEP:  phase_step_per_hz <= pwdata[19:0];
        REG_OVS:   oversample_log2   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PITCH: prdata = 32'(pitch_offset);
      REG_RATIO: prdata = 32'(ratio_knob);
      REG_DEPTH: prdata = 32'(depth_knob);
      REG_DELAY: prdata = 32'(delay_knob);
      REG_STEP:  prdata = 32'(phase_step_per_hz);
      REG_OVS:   prdata = 32'(oversample_log2);
      default:   prdata = 32'd0;
    endcase
  end

  // sequencer and datapath registers
  fsm_state_t state, state_next;
  sine_op_t   op;
  item_t      req;
  logic       bad_voice;
  logic [2:0] step;
  logic [4:0] e_idx;
  logic [14:0] zq;
  logic [16:0] ex;
  logic [45:0] f0;
  logic [15:0] m, a;
  logic [31:0] inc1, inc2, rt, x2, arg;
  logic signed [17:0] t;
  logic [15:0] sz, z2;
  logic [1:0]  sq;
  logic signed [15:0] y;
  logic signed [18:0] sum;

  logic [PHASE_BITS-1:0] carrier_phase [VOICES];
  logic [PHASE_BITS-1:0] second_phase  [VOICES];
  logic [PHASE_BITS-1:0] third_phase   [VOICES];

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;

  cfmo_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  function automatic logic [PHASE_BITS-1:0] to_store(logic [31:0] v);
    logic [PHASE_BITS+31:0] w;
    w = ({(PHASE_BITS)'(0), v} << SH_UP) >> SH_DN;
    return w[PHASE_BITS-1:0];
  endfunction

  function automatic logic [31:0] from_store(logic [PHASE_BITS-1:0] v);
    logic [PHASE_BITS+31:0] w;
    w = ({32'd0, v} << SH_DN) >> SH_UP;
    return w[31:0];
  endfunction

  logic          accept;
  logic [VW-1:0] vidx;
  logic [31:0]   p15, ph1, ph2, ph3;
  logic [55:0]   t56, d2, d3;
  logic signed [18:0] psum, psat;
  logic [18:0]   pbias;
  logic [14:0]   zc;
  logic [5:0]    shamt;
  logic signed [17:0] tc;
  logic          last_step;
  logic [31:0]   mt;

  assign accept = item_valid && !item_stall;
  assign vidx   = req.voice[VW-1:0];
  assign p15    = prod[46:15];
  assign ph1    = from_store(carrier_phase[vidx]);
  assign ph2    = from_store(second_phase[vidx]);
  assign ph3    = from_store(third_phase[vidx]);
  assign t56    = {{38{t[17]}}, t};
  assign d2     = {24'd0, ph2} - (t56 << 20);
  assign d3     = {24'd0, ph3} - (t56 << 21);
  assign shamt  = 6'd47 + 6'(oversample_log2) - 6'(e_idx);
  assign tc     = $signed({3'd0, delay_knob}) + $signed({req.delay_cv[15], req.delay_cv, 1'b0});
  assign last_step = (step == 3'((4'd1 << oversample_log2) - 4'd1));
  assign mt     = prod[46:15];

  // pitch in Q.12 volts, saturated to plus or minus 16 V
  always_comb begin
    psum = $signed({6'd0, pitch_offset}) + $signed({{2{req.note_cv[15]}}, req.note_cv, 1'b0});
    psat = psum;
    if (psum < -19'sd65536) psat = -19'sd65536;
    if (psum > 19'sd65535)  psat = 19'sd65535;
    pbias = 19'(psat + 19'sd65536);
    zc    = {pbias[11:0], 3'd0};
  end

  // sine argument: round to table point, fold into first quadrant, clamp the magnitude
  logic [31:0]    sin_rnd;
  logic [STB-1:0] sin_k;
  logic [1:0]     sin_q;
  logic [STB-2:0] sin_r;
  logic [15:0]    sin_z;
  logic [16:0]    sin_mag;
  logic [15:0]    sin_y;
  always_comb begin
    sin_rnd = arg + (32'd1 << (31 - STB));
    sin_k   = sin_rnd[31 -: STB];
    sin_q   = sin_k[STB-1 -: 2];
    sin_r   = {1'b0, sin_k[STB-3:0]};
    if (sin_q[0]) sin_r = (STB-1)'(1 << (STB - 2)) - sin_r;
    sin_z   = 16'(sin_r) << (17 - STB);
    sin_mag = p15[16:0];
    sin_y   = (sin_mag > 17'd32767) ? 16'd32767 : sin_mag[15:0];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) begin
        state_next = ({1'b0, item.voice} >= 5'(VOICES)) ? ST_OUT : ST_EX1;
      end
      ST_EX1:   state_next = ST_EX2;
      ST_EX2:   state_next = ST_EX3;
      ST_EX3:   state_next = ST_BASE1;
      ST_BASE1: state_next = ST_BASE2;
      ST_BASE2: state_next = ST_F0;
      ST_F0:    state_next = ST_RDIV;
      ST_RDIV:  state_next = ST_RSAT;
      ST_RSAT:  state_next = ST_DDIV;
      ST_DDIV:  state_next = ST_DSAT;
      ST_DSAT:  state_next = ST_F1;
      ST_F1:    state_next = ST_F2;
      ST_F2:    state_next = ST_RT;
      ST_RT:    state_next = ST_ADV;
      ST_ADV:   state_next = ST_X2;
      ST_X2:    state_next = ST_X3A;
      ST_X3A:   state_next = ST_X3B;
      ST_X3B:   state_next = ST_X3C;
      ST_X3C:   state_next = ST_SIN_A;
      ST_SIN_A: state_next = ST_SIN_B;
      ST_SIN_B: state_next = ST_SIN_C;
      ST_SIN_C: state_next = ST_SIN_D;
      ST_SIN_D: state_next = ST_SIN_E;
      ST_SIN_E: begin
        if (op == OP_Y4) state_next = last_step ? ST_OUT : ST_ADV;
        else             state_next = ST_MT1;
      end
      ST_MT1:   state_next = ST_MT2;
      ST_MT2:   state_next = ST_MT3;
      ST_MT3:   state_next = ST_SIN_A;
      ST_OUT:   if (!result_valid || !result_stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_EX1:   begin mul_a = 56'd2557;                mul_b = 20'(zc); end
      ST_EX2:   begin mul_a = 56'(32'd7419 + p15);     mul_b = 20'(zq); end
      ST_EX3:   begin mul_a = 56'(32'd22790 + p15);    mul_b = 20'(zq); end
      ST_BASE1: begin mul_a = 56'(C4_Q16);             mul_b = phase_step_per_hz; end
      ST_BASE2: begin mul_a = 56'(prod[44:0]);         mul_b = 20'(ex); end
      ST_F0:    begin mul_a = 56'(ratio_knob);         mul_b = 20'(req.ratio_cv[14:0]); end
      ST_RDIV:  begin mul_a = 56'(prod[30:12]);        mul_b = 20'(DIV5_RECIP); end
      ST_RSAT:  begin mul_a = 56'(depth_knob);         mul_b = 20'(req.depth_cv[14:0]); end
      ST_DDIV:  begin mul_a = 56'(prod[30:12]);        mul_b = 20'(DIV5_RECIP); end
      ST_DSAT:  begin mul_a = 56'(f0);                 mul_b = 20'(m); end
      ST_F1:    begin mul_a = 56'(prod[55:12]);        mul_b = 20'(m); end
      ST_F2:    begin mul_a = {{38{tc[17]}}, tc};      mul_b = 20'(TURNS_PER_RAD); end
      ST_X2:    begin mul_a = d2;                      mul_b = 20'(m); end
      ST_X3A:   begin mul_a = d3;                      mul_b = 20'(m); end
      ST_X3B:   begin mul_a = prod[55:0];              mul_b = 20'(m); end
      ST_SIN_A: begin mul_a = 56'(sin_z);              mul_b = 20'(sin_z); end
      ST_SIN_B: begin mul_a = 56'(p15[15:0]);          mul_b = 20'd2320; end
      ST_SIN_C: begin mul_a = 56'(32'd21024 - p15);    mul_b = 20'(z2); end
      ST_SIN_D: begin mul_a = 56'(32'd51472 - p15);    mul_b = 20'(sz); end
      ST_MT1:   begin mul_a = {{40{y[15]}}, y};        mul_b = 20'(a); end
      ST_MT2:   begin mul_a = prod[55:0];              mul_b = 20'(TURNS_PER_RAD); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign item_stall = (state != ST_IDLE);

  // output sample
  logic signed [21:0] sum5, sum_sh;
  always_comb begin
    sum5   = ($signed({{3{sum[18]}}, sum}) <<< 2) + $signed({{3{sum[18]}}, sum});
    sum_sh = sum5 >>> (3'd4 + 3'(oversample_log2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_OUT && (!result_valid || !result_stall)) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!result_valid || !result_stall)) begin
      result.out_voice <= req.voice;
      result.audio_out <= bad_voice ? 16'sd0 : sum_sh[15:0];
    end
  end

  // phase accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VOICES; i++) begin
        carrier_phase[i] <= '0;
        second_phase[i]  <= '0;
        third_phase[i]   <= '0;
      end
    end else if (state == ST_ADV) begin
      carrier_phase[vidx] <= carrier_phase[vidx] + to_store(f0[31:0]);
      second_phase[vidx]  <= second_phase[vidx] + to_store(inc1);
      third_phase[vidx]   <= third_phase[vidx] + to_store(inc2);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (accept) begin
        req       <= item;
        bad_voice <= ({1'b0, item.voice} >= 5'(VOICES));
        sum       <= '0;
        step      <= '0;
      end
      ST_EX1:   begin e_idx <= pbias[16:12]; zq <= zc; end
      ST_BASE1: ex <= 17'(32'd32768 + p15);
      ST_F0:    f0 <= 46'(prod[61:0] >> shamt);
      ST_RSAT:  m <= knob_scale(ratio_knob, req.ratio_cv, req.ratio_patched, prod[37:21]);
      ST_DSAT:  a <= knob_scale(16'(depth_knob), req.depth_cv, req.depth_patched, prod[37:21]);
      ST_F1:    inc1 <= prod[43:12];
      ST_F2:    begin inc2 <= prod[43:12]; t <= tc; end
      ST_RT:    rt <= prod[31:0];
      ST_X3A:   x2 <= prod[43:12];
      ST_X3C:   begin arg <= prod[55:24] - (rt << 1); op <= OP_Y2; end
      ST_SIN_A: begin sz <= sin_z; sq <= sin_q; end
      ST_SIN_B: z2 <= p15[15:0];
      ST_SIN_E: begin
        y <= sq[1] ? -$signed(sin_y) : $signed(sin_y);
        if (op == OP_Y4) begin
          sum  <= sum + 19'(sq[1] ? -$signed(sin_y) : $signed(sin_y));
          step <= step + 3'd1;
        end
      end
      ST_MT3: begin
        if (op == OP_Y2) begin
          arg <= x2 - rt + mt;
          op  <= OP_Y3;
        end else begin
          arg <= ph1 + mt;
          op  <= OP_Y4;
        end
      end
      default: ;
    endcase
  end

  // a request is never taken twice in a row
  assert property (@(posedge clk) disable iff (rst)
    accept |=> item_stall)
    else $error("request accepted while busy");

  // a finished sample always lands in the output register
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && (!result_valid || !result_stall)) |=>
      (result_valid && state == ST_IDLE))
    else $error("result not delivered");

  // quadrant fold keeps the sine input within one quarter turn
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SIN_A) |-> (sin_z <= 16'd32768))
    else $error("sine fold out of range");

  // sub-step count never passes the oversampling factor
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADV) |-> (4'(step) < (4'd1 << oversample_log2)))
    else $error("sub-step overrun");

endmodule

`default_nettype wire

// File: sim/tb.sv
`default_nettype none

module tb
  import cfmo_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NVOICE = 16;
  localparam int SINE_W = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  always #5 clk = ~clk;

  cascaded_fm_oscillator dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor copy of registers and phase accumulators
  logic [12:0] pitch_r;
  logic [15:0] ratio_r;
  logic [13:0] depth_r;
  logic [14:0] delay_r;
  logic [19:0] step_r;
  logic [1:0]  ovs_r;
  logic [31:0] ph_car [NVOICE];
  logic [31:0] ph_sec [NVOICE];
  logic [31:0] ph_thr [NVOICE];

  result_t expected_samples[$];
  int errors = 0;
  bit sending_done = 0;
  bit hold_rx = 0;

  function automatic int signed sine15(logic [31:0] ph);
    logic [31:0] k, q, r, z, z2, p, y;
    k = ((ph + (32'd1 << (31 - SINE_W))) >> (32 - SINE_W)) & ((1 << SINE_W) - 1);
    q = k >> (SINE_W - 2);
    r = k & ((1 << (SINE_W - 2)) - 1);
    if (q[0]) r = (1 << (SINE_W - 2)) - r;
    z = r << (17 - SINE_W);
    z2 = (z * z) >> 15;
    p = 32'd21024 - ((32'd2320 * z2) >> 15);
    p = 32'd51472 - ((p * z2) >> 15);
    y = (p * z) >> 15;
    if (y > 32767) y = 32767;
    return q[1] ? -int'(y) : int'(y);
  endfunction

  function automatic logic [63:0] scale_knob(logic [63:0] knob, longint cv, logic patched);
    logic [63:0] v;
    v = knob;
    if (patched) v = (cv > 0) ? (knob * 64'(cv)) / 64'd20480 : 64'd0;
    return (v > 65535) ? 64'd65535 : v;
  endfunction

  function automatic logic [31:0] mod_to_turns(logic [63:0] a, int signed s);
    longint prod;
    prod = longint'(a) * longint'(s);
    return 32'((64'(prod) * 64'd166886) >> 15);
  endfunction

  function automatic result_t fm_sample(item_t it);
    result_t r;
    longint p, t, tq, acc, tot;
    logic [63:0] m, m2, a, base, f0, f1, f2, ex, z;
    logic [31:0] eidx, sh, x2, x3, arg, fr;
    int signed y;
    int v;
    r.out_voice = it.voice;
    r.audio_out = '0;
    v = it.voice;
    if (v >= NVOICE) return r;
    p = longint'(pitch_r) + 2 * longint'(it.note_cv);
    if (p < -65536) p = -65536;
    if (p > 65535) p = 65535;
    eidx = 32'(p + 65536) >> 12;
    fr = 32'(p + 65536) & 32'd4095;
    z = 64'(fr) << 3;
    ex = 64'd2557;
    ex = 64'd7419 + ((ex * z) >> 15);
    ex = 64'd22790 + ((ex * z) >> 15);
    ex = 64'd32768 + ((ex * z) >> 15);
    base = 64'd17145893 * 64'(step_r) * ex;
    sh = 32'd47 + ovs_r - eidx;
    f0 = base >> sh;
    m = scale_knob(ratio_r, it.ratio_cv, it.ratio_patched);
    a = scale_knob(depth_r, it.depth_cv, it.depth_patched);
    m2 = m * m;
    f1 = (f0 * m) >> 12;
    f2 = (f1 * m) >> 12;
    t = longint'(delay_r) + 2 * longint'(it.delay_cv);
    tq = t * 1048576;
    acc = 0;
    for (int i = 0; i < (1 << ovs_r); i++) begin
      ph_car[v] += f0[31:0];
      ph_sec[v] += f1[31:0];
      ph_thr[v] += f2[31:0];
      x2 = 32'((64'(longint'(ph_sec[v]) - tq) * m) >> 12);
      x3 = 32'((64'(longint'(ph_thr[v]) - 2 * tq) * m2) >> 24);
      y = sine15(x3 - 32'(64'(2 * t) * 64'd166886));
      arg = x2 - 32'(64'(t) * 64'd166886) + mod_to_turns(a, y);
      y = sine15(arg);
      arg = ph_car[v] + mod_to_turns(a, y);
      acc += sine15(arg);
    end
    tot = acc * 5;
    // floor division by power of two
    r.audio_out = 16'(tot >>> (4 + ovs_r));
    return r;
  endfunction

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= APB_AW'(4 * idx); pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_PITCH: pitch_r = val[12:0];
      REG_RATIO: ratio_r = val[15:0];
      REG_DEPTH: depth_r = val[13:0];
      REG_DELAY: delay_r = val[14:0];
      REG_STEP:  step_r  = val[19:0];
      REG_OVS:   ovs_r   = val[1:0];
      default: ;
    endcase
  endtask

  task automatic drain_wait();
    item_valid <= 1'b0;
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  // valid stays up after an accepted request when the next one follows at once
  task automatic send_request(item_t it, int gap);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    expected_samples.push_back(fm_sample(it));
    @(negedge clk);
  endtask

  function automatic item_t rand_request();
    item_t it;
    it = item_t'($bits(item_t)'({$urandom, $urandom, $urandom}));
    it.voice = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 3) != 0) it.note_cv = 16'($signed($urandom_range(0, 16000)) - 8000);
    if ($urandom_range(0, 3) != 0) it.ratio_cv = 16'($urandom_range(0, 20480));
    if ($urandom_range(0, 3) != 0) it.depth_cv = 16'($urandom_range(0, 20480));
    if ($urandom_range(0, 2) != 0) it.delay_cv = 16'($signed($urandom_range(0, 8000)) - 4000);
    return it;
  endfunction

  // directed rows: voice, note, ratio cv, ratio patched, depth cv, depth patched, delay
  item_t directed [] = '{
    '{4'd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0, 16'sd0},
    '{4'd15, 16'sh7FFF, 16'sh7FFF, 1'b1, 16'sh7FFF, 1'b1, 16'sh7FFF},
    '{4'd1, 16'sh8000, 16'sh8000, 1'b1, 16'sh8000, 1'b1, 16'sh8000},
    '{4'd2, 16'sd2048, 16'sd20480, 1'b1, 16'sd10240, 1'b1, 16'sd0},
    '{4'd3, -16'sd2048, 16'sd0, 1'b1, -16'sd1, 1'b1, 16'sd100},
    '{4'd4, 16'sd30000, 16'sd1, 1'b1, 16'sd1, 1'b1, -16'sd100},
    '{4'd5, -16'sd30000, 16'sd5000, 1'b0, 16'sd5000, 1'b0, 16'sd12868},
    '{4'd0, 16'sd100, 16'sd0, 1'b0, 16'sd0, 1'b0, 16'sd0},
    '{4'd7, 16'sd0, 16'sd0, 1'b0, 16'sd20480, 1'b1, 16'sd0}
  };

  initial begin
    pitch_r = PITCH_RST; ratio_r = RATIO_RST; depth_r = DEPTH_RST;
    delay_r = DELAY_RST; step_r = STEP_RST; ovs_r = OVS_RST;
    for (int i = 0; i < NVOICE; i++) begin
      ph_car[i] = '0; ph_sec[i] = '0; ph_thr[i] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // first request after reset: zero phases, zero depth gives a known sine sample
    foreach (directed[i]) send_request(directed[i], $urandom_range(0, 8));
    drain_wait();
    reg_write(REG_DEPTH, 32'd12288);
    reg_write(REG_DELAY, 32'd25736);
    reg_write(REG_RATIO, 32'd40960);
    reg_write(REG_PITCH, 32'd4096);
    reg_write(REG_STEP, 32'd1048575);
    reg_write(REG_OVS, 32'd3);
    foreach (directed[i]) send_request(directed[i], 0);
    drain_wait();
    for (int ph = 0; ph < 8; ph++) begin
      reg_write(REG_PITCH, (ph == 1) ? 32'd0 : $urandom_range(0, 4096));
      reg_write(REG_RATIO, (ph == 1) ? 32'd0 : $urandom_range(0, 40960));
      reg_write(REG_DEPTH, (ph == 2) ? 32'd0 : $urandom_range(0, 12288));
      reg_write(REG_DELAY, (ph == 2) ? 32'd0 : $urandom_range(0, 25736));
      reg_write(REG_STEP, (ph == 3) ? 32'd0 : $urandom_range(0, 1048575));
      reg_write(REG_OVS, (ph < 4) ? ph : $urandom_range(0, 3));
      if (ph == 4) hold_rx = 1;
      for (int n = 0; n < 135; n++)
        send_request(rand_request(), (n % 40 < 10) ? 0 : $urandom_range(0, 8));
      drain_wait();
    end
    sending_done = 1;
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    int w;
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        hold_rx = 0;
        result_stall <= 1'b1;
        repeat (2000) @(negedge clk);
        result_stall <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        w = $urandom_range(0, 8);
        if (w != 0) begin
          result_stall <= 1'b1;
          repeat (w) @(negedge clk);
          result_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && result_valid && !result_stall) begin
      if (expected_samples.size() == 0) begin
        $error("unexpected result voice %0d", result.out_voice);
        errors++;
      end else begin
        exp_r = expected_samples.pop_front();
        if (result.out_voice !== exp_r.out_voice) begin
          $error("out_voice expected %0d actual %0d", exp_r.out_voice, result.out_voice);
          errors++;
        end
        if (result.audio_out !== exp_r.audio_out) begin
          $error("audio_out expected %0d actual %0d", exp_r.audio_out, result.audio_out);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (sending_done);
    if (errors == 0 && expected_samples.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
rtl/core/cfmo_pkg.sv
rtl/core/cfmo_mul.sv
rtl/core/cascaded_fm_oscillator.sv
sim/tb.sv
